/* sv/psl_pkg.sv */
`default_nettype none
package psl_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LIMIT_W     = 16;
    localparam int QUERY_W     = 16;
    // odd candidate i runs while i*i <= limit, so it needs about half the address bits
    localparam int I_W         = (ADDR_W + 1) / 2 + 2;
    localparam int SQ_W        = 2 * I_W;
    // multiple pointer: one extra bit so it can step past the limit
    localparam int J_W         = ADDR_W + 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65535);
    localparam logic [31:0]        MAX_COVER   = 32'(TABLE_DEPTH - 1);

    // first odd candidate and the stride between candidates
    localparam int FIRST_ODD = 3;
    localparam int ODD_STEP  = 2;

    typedef enum logic [2:0] {
        ST_NEED,
        ST_INIT,
        ST_TEST,
        ST_CHECK,
        ST_CLEAR,
        ST_READY
    } t_psl_state;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic              wdata;
    } t_psl_mem_req;

endpackage
`default_nettype wire

/* sv/prime_sieve_lookup.sv */
// A query's result is valid in the cycle after the item is accepted.
// Throughput: one query per cycle once the table is built, while the output is not stalled (one flag RAM read).
// Build: the first query after reset or a limit write waits for the start state, the fill of
// flags 0..limit, a test and a check per odd candidate with square <= limit, a clear per multiple, a final test.
// Reset (synchronous, active low): limit returns to 65535, table marked unbuilt,
// output empty; the flag RAM is not cleared.
`default_nettype none
module prime_sieve_lookup (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [15:0] i_cfg_wdata,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [15:0] i_query_number,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_is_prime,
    output logic        o_out_of_range
);
    import psl_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic               r_rd_v, n_rd_v;
    logic               r_oor;

    logic [31:0]        cov32;
    logic [ADDR_W-1:0]  cov;
    logic               ready;
    logic               can_take;
    logic               accept;
    logic               start;
    logic               oor;
    logic               rdata;
    t_psl_mem_req       ctrl_req;
    t_psl_mem_req       mem_req;

    // clamp the limit to the table
    assign cov32 = (32'(r_limit) > MAX_COVER) ? MAX_COVER : 32'(r_limit);
    assign cov   = cov32[ADDR_W-1:0];
    assign oor   = 32'(i_query_number) > cov32;

    // take an item when built and the result slot is empty or frees this cycle
    assign can_take   = ready && (!r_rd_v || !i_out_stall);
    assign o_in_stall = !can_take;
    assign accept     = i_in_valid && can_take;
    assign start      = i_in_valid && !ready && !r_rd_v;

    psl_sieve_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_rebuild (i_cfg_we),
        .i_lim     (cov),
        .i_rdata   (rdata),
        .o_req     (ctrl_req),
        .o_ready   (ready)
    );

    // queries own the RAM once the table is built
    always_comb begin
        if (ready) begin
            mem_req.we    = 1'b0;
            mem_req.re    = accept;
            mem_req.addr  = ADDR_W'(i_query_number);
            mem_req.wdata = 1'b0;
        end else begin
            mem_req = ctrl_req;
        end
    end

    psl_flag_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    // hold the result while stalled, drop it once taken
    always_comb begin
        if (accept) begin
            n_rd_v = 1'b1;
        end else if (i_out_stall) begin
            n_rd_v = r_rd_v;
        end else begin
            n_rd_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_rd_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_rd_v <= n_rd_v;
        end
        if (accept) begin
            r_oor <= oor;
        end
    end

    assign o_out_valid    = r_rd_v;
    assign o_is_prime     = rdata && !r_oor;
    assign o_out_of_range = r_oor;

endmodule
`default_nettype wire

/* sv/psl_flag_ram.sv */
`default_nettype none
module psl_flag_ram (
    input  wire                        i_clk,
    input  wire psl_pkg::t_psl_mem_req i_req,
    output logic                       o_rdata
);
    import psl_pkg::*;

    logic r_mem [TABLE_DEPTH];

    // write on we, registered read on re; data holds otherwise
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.addr];
        end
    end

endmodule
`default_nettype wire

/* sv/psl_sieve_ctrl.sv */
`default_nettype none
module psl_sieve_ctrl (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire                        i_rebuild,
    input  wire  [psl_pkg::ADDR_W-1:0] i_lim,
    input  wire                        i_rdata,
    output psl_pkg::t_psl_mem_req      o_req,
    output logic                       o_ready
);
    import psl_pkg::*;

    t_psl_state      r_state, n_state;
    logic [I_W-1:0]  r_i, n_i;
    logic [SQ_W-1:0] r_sq, n_sq;
    logic [J_W-1:0]  r_j, n_j;

    logic [J_W-1:0]  sum_j;
    logic [SQ_W-1:0] next_sq;
    logic            sq_over;
    logic            init_last;
    logic            init_bit;

    // shared arithmetic for the sweep
    assign sum_j     = r_j + J_W'(r_i);
    assign next_sq   = r_sq + (SQ_W'(r_i) << 2) + SQ_W'(4);
    assign sq_over   = r_sq > SQ_W'(i_lim);
    assign init_last = r_j == J_W'(i_lim);
    // 2 is prime, other evens and 1 composite, odd numbers start prime
    assign init_bit  = (r_j == J_W'(2)) || (r_j[0] && (r_j != J_W'(1)));

    // next state and sweep counters
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_sq    = r_sq;
        n_j     = r_j;
        if (i_rebuild) begin
            n_state = ST_NEED;
        end else begin
            case (r_state)
                ST_NEED: begin
                    if (i_start) begin
                        n_state = ST_INIT;
                        n_j     = '0;
                    end
                end
                ST_INIT: begin
                    if (init_last) begin
                        n_state = ST_TEST;
                        n_i     = I_W'(FIRST_ODD);
                        n_sq    = SQ_W'(FIRST_ODD * FIRST_ODD);
                    end else begin
                        n_j = r_j + J_W'(1);
                    end
                end
                ST_TEST: begin
                    n_state = sq_over ? ST_READY : ST_CHECK;
                end
                ST_CHECK: begin
                    if (i_rdata) begin
                        n_state = ST_CLEAR;
                        n_j     = J_W'(r_sq);
                    end else begin
                        n_state = ST_TEST;
                        n_i     = r_i + I_W'(ODD_STEP);
                        n_sq    = next_sq;
                    end
                end
                ST_CLEAR: begin
                    if (sum_j > J_W'(i_lim)) begin
                        n_state = ST_TEST;
                        n_i     = r_i + I_W'(ODD_STEP);
                        n_sq    = next_sq;
                    end else begin
                        n_j = sum_j;
                    end
                end
                ST_READY: begin
                    n_state = ST_READY;
                end
                default: begin
                    n_state = ST_NEED;
                end
            endcase
        end
    end

    // memory requests for fill, candidate read and multiple clearing
    always_comb begin
        o_req       = '0;
        o_req.addr  = r_j[ADDR_W-1:0];
        o_ready     = 1'b0;
        case (r_state)
            ST_INIT: begin
                o_req.we    = 1'b1;
                o_req.wdata = init_bit;
            end
            ST_TEST: begin
                o_req.re   = !sq_over;
                o_req.addr = ADDR_W'(r_i);
            end
            ST_CLEAR: begin
                o_req.we    = 1'b1;
                o_req.wdata = 1'b0;
            end
            ST_READY: begin
                o_ready = 1'b1;
            end
            default: begin
                o_req.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_NEED;
        end else begin
            r_state <= n_state;
        end
        r_i  <= n_i;
        r_sq <= n_sq;
        r_j  <= n_j;
    end

endmodule
`default_nettype wire

/* sv/psl_checker.sv */
`default_nettype none
module psl_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_stall,
    input wire [15:0] i_query_number,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire        o_is_prime,
    input wire        o_out_of_range
);

    logic in_take;
    logic never_prime;

    assign in_take     = i_in_valid && !o_in_stall;
    // 0, 1 and even numbers other than 2 are never prime, whatever the limit
    assign never_prime = (i_query_number < 16'd2) ||
                         (!i_query_number[0] && (i_query_number != 16'd2));

    // every accepted item shows a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_out_valid)
        else $error("accepted item produced no result");

    // no result appears without an accepted item
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_take))
        else $error("result without accepted item");

    // out of range results never claim primality
    a_oor_not_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> !o_is_prime)
        else $error("out of range result flagged prime");

    // numbers that are never prime read as not prime
    a_trivial_composite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && never_prime) |=> !o_is_prime)
        else $error("composite number reported prime");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_is_prime) && $stable(o_out_of_range)))
        else $error("stalled result changed");

endmodule

bind prime_sieve_lookup psl_checker u_psl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_query_number (i_query_number),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_is_prime     (o_is_prime),
    .o_out_of_range (o_out_of_range)
);
`default_nettype wire
